[rtl/gsl_pkg.sv]
// Shared types, constants and constant tables for the gas sensor linearizer.
package gsl_pkg;

  // Converter and fixed-point formats
  localparam int ADC_BITS        = 10;
  localparam int FRAC_BITS       = 10;
  localparam int LOG_TABLE_DEPTH = 256;
  localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);

  localparam int VAL_W   = 20;
  localparam int SUM_W   = 26;
  localparam int WIN_W   = 7;
  localparam int LOAD_W  = 7;
  localparam int FAC_W   = 18;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 3;

  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  localparam logic [VAL_W-1:0]    VAL_MAX = {VAL_W{1'b1}};
  localparam logic [WIN_W-1:0]    WIN_MAX = 7'd64;

  // Serial arithmetic unit widths
  localparam int DIV_DVD_W = 32;
  localparam int DIV_DSR_W = 18;
  localparam int MUL_W     = 32;
  localparam int NORM_W    = VAL_W;
  localparam int NORM_E_W  = $clog2(NORM_W);

  // Q16 constants
  localparam logic [17:0] LOG10_2_Q16 = 18'd19728;
  localparam logic [17:0] LOG2_10_Q16 = 18'd217706;
  localparam logic [17:0] COEF_A_MAG [2] = '{18'd0, 18'd44060};
  localparam logic [17:0] COEF_B_MAG [2] = '{18'd172779, 18'd157221};
  localparam logic [17:0] COEF_C_MAG [2] = '{18'd238977, 18'd239488};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_MODE,
    REG_LOAD_KOHM,
    REG_CLEAN_AIR,
    REG_CAL_WINDOW,
    REG_MEAS_WINDOW
  } cfg_reg_t;

  // Input and result beats
  typedef struct packed {
    logic                command;
    logic [ADC_BITS-1:0] adc_sample;
  } gsl_in_t;

  typedef struct packed {
    logic             result_kind;
    logic [VAL_W-1:0] result_value;
    logic             saturated;
    logic             uncalibrated;
  } gsl_out_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_RS_GO, S_RS_WAIT, S_ACCUM, S_CHECK, S_AVG_WAIT, S_DISPATCH,
    S_REF_WAIT, S_LOGA_WAIT, S_LOGB_GO, S_LOGB_WAIT, S_LG_GO, S_LG_WAIT,
    S_SQ_GO, S_SQ_WAIT, S_A_GO, S_A_WAIT, S_B_GO, S_B_WAIT, S_T_GO,
    S_T_WAIT, S_EXP_BIT, S_EXP_WAIT, S_EXP_FIN, S_OUT
  } gsl_state_t;

  typedef logic [15:0] log_rom_t [LOG_TABLE_DEPTH];
  typedef logic [31:0] root_rom_t [17];

  // log2(1 + i/DEPTH) in Q16 by repeated squaring in Q30
  function automatic log_rom_t build_log_rom();
    log_rom_t    rom;
    logic [63:0] v;
    logic [15:0] r;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      v = (64'(LOG_TABLE_DEPTH + i) << 30) / LOG_TABLE_DEPTH;
      r = '0;
      for (int k = 0; k < 16; k++) begin
        v = (v * v) >> 30;
        r = {r[14:0], 1'b0};
        if (v >= (64'd2 << 30)) begin
          v    = v >> 1;
          r[0] = 1'b1;
        end
      end
      rom[i] = r;
    end
    return rom;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q30 as a chain of square roots from 2.0
  function automatic root_rom_t build_root_rom();
    root_rom_t rom;
    rom[0] = 32'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      rom[k] = 32'(isqrt64(64'(rom[k-1]) << 30));
    end
    return rom;
  endfunction

  localparam log_rom_t  LOG_ROM  = build_log_rom();
  localparam root_rom_t ROOT_ROM = build_root_rom();

endpackage

[rtl/gsl_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
module gsl_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [gsl_pkg::DIV_DVD_W-1:0]     dividend,
  input  logic [gsl_pkg::DIV_DSR_W-1:0]     divisor,
  output logic                              done,
  output logic [gsl_pkg::DIV_DVD_W-1:0]     quotient
);
  import gsl_pkg::*;

  localparam int CNT_W = $clog2(DIV_DVD_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DSR_W-1:0] dsr;
  logic [DIV_DSR_W-1:0] rem;
  logic [DIV_DVD_W-1:0] quo;
  logic [DIV_DSR_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_DSR_W:0]   diff;

  // trial subtract of the next dividend bit
  assign rem_sh   = {rem, quo[DIV_DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign diff     = rem_sh - {1'b0, dsr};
  assign quotient = quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_DVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DSR_W-1:0] : rem_sh[DIV_DSR_W-1:0];
      quo <= {quo[DIV_DVD_W-2:0], ge};
    end
  end

endmodule

[rtl/gsl_mul.sv]
// Shift-add serial multiplier, one multiplier bit per cycle.
module gsl_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gsl_pkg::MUL_W-1:0]   a,
  input  logic [gsl_pkg::MUL_W-1:0]   b,
  output logic                        done,
  output logic [2*gsl_pkg::MUL_W-1:0] product
);
  import gsl_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_W-1:0]   mcand;
  logic [MUL_W-1:0]   mplier;
  logic [2*MUL_W-1:0] acc;
  logic [MUL_W:0]     hi_sum;

  assign hi_sum  = {1'b0, acc[2*MUL_W-1:MUL_W]} + (mplier[0] ? {1'b0, mcand} : '0);
  assign product = acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MUL_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // add and shift right
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      acc    <= '0;
    end else if (busy) begin
      acc    <= {hi_sum, acc[MUL_W-1:1]};
      mplier <= mplier >> 1;
    end
  end

endmodule

[rtl/gsl_norm.sv]
// Serial normalizer: shifts until the leading one reaches the top bit.
module gsl_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gsl_pkg::NORM_W-1:0]     x,
  output logic                           done,
  output logic [gsl_pkg::NORM_E_W-1:0]   msb,
  output logic [gsl_pkg::NORM_W-1:0]     mant
);
  import gsl_pkg::*;

  logic busy;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && mant[NORM_W-1]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one position per cycle; input is never zero
  always_ff @(posedge clk) begin
    if (start) begin
      mant <= x;
      msb  <= NORM_E_W'(NORM_W - 1);
    end else if (busy && !mant[NORM_W-1]) begin
      mant <= {mant[NORM_W-2:0], 1'b0};
      msb  <= msb - 1'b1;
    end
  end

endmodule

[rtl/gas_sensor_ppm_linearizer.sv]
// Top level: window averaging, calibration and ppm curve sequencer.
//
//  channel | signals                     | direction
//  --------+-----------------------------+----------
//  input   | in_valid, in_stall, in_data | in
//  result  | out_valid, out_stall, out_data | out
//  config  | cfg_write, cfg_index, cfg_data | in
//
// Each sample beat waits on the serial divider that forms the sensor resistance;
// a zero sample skips the divider. A window end adds a serial division for the
// average; calibration adds another, measurement two normalizations, then five
// serial products and up to sixteen more for the exponent. Synchronous reset
// restores defaults; a stalled result holds only a window end, not samples.
module gas_sensor_ppm_linearizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gsl_pkg::gsl_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gsl_pkg::gsl_out_t                 out_data,
  input  logic                              cfg_write,
  input  logic [gsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsl_pkg::CFG_W-1:0]         cfg_data
);
  import gsl_pkg::*;

  gsl_state_t state, state_next;

  // configuration registers
  logic              curve_mode;
  logic [LOAD_W-1:0] load_kohm;
  logic [FAC_W-1:0]  clean_air;
  logic [WIN_W-1:0]  cal_window;
  logic [WIN_W-1:0]  meas_window;

  // window state
  logic             cmd;
  logic [ADC_BITS-1:0] adc;
  logic [VAL_W-1:0] rs_val;
  logic [SUM_W-1:0] sum;
  logic [WIN_W-1:0] count;
  logic             phase;
  logic [VAL_W-1:0] ref_res;
  logic             sat_seen;
  logic [VAL_W-1:0] avg;

  // curve evaluation
  logic [20:0]        log_a;
  logic [20:0]        log_b;
  logic               lg_neg;
  logic [19:0]        lg_mag;
  logic [23:0]        sq;
  logic [23:0]        ta;
  logic signed [25:0] y;
  logic signed [11:0] n;
  logic [15:0]        f;
  logic [30:0]        man;
  logic [4:0]         k;

  // result being built
  logic [VAL_W-1:0] res_val;
  logic             res_sat;
  logic             res_uncal;

  // unit ports
  logic                 div_start, div_done;
  logic [DIV_DVD_W-1:0] div_dividend, div_quotient;
  logic [DIV_DSR_W-1:0] div_divisor;
  logic                 mul_start, mul_done;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic                 norm_start, norm_done;
  logic [NORM_W-1:0]    norm_x, norm_mant;
  logic [NORM_E_W-1:0]  norm_msb;

  gsl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quotient)
  );

  gsl_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  gsl_norm u_norm (
    .clk(clk), .rst(rst), .start(norm_start), .x(norm_x),
    .done(norm_done), .msb(norm_msb), .mant(norm_mant)
  );

  // derived values
  logic [WIN_W-1:0]        win_raw, win_eff;
  logic                    win_end;
  logic [LOAD_W+ADC_BITS-1:0] rs_num;
  logic [FAC_W-1:0]        fac_eff;
  logic [20:0]             log_now;
  logic signed [21:0]      d;
  logic [21:0]             d_mag;
  logic [21:0]             tb;
  logic signed [25:0]      y_next;
  logic [24:0]             y_mag;
  logic [26:0]             t_mag;
  logic signed [27:0]      t;
  logic                    f_bit;
  logic                    out_free;
  logic signed [11:0]      shift_s;
  logic [63:0]             exp_val;

  assign win_raw = cmd ? meas_window : cal_window;
  assign win_eff = (win_raw == '0) ? WIN_W'(1) : (win_raw > WIN_MAX) ? WIN_MAX : win_raw;
  assign win_end = count >= win_eff;
  assign rs_num  = load_kohm * (ADC_MAX - adc);
  assign fac_eff = (clean_air == '0) ? FAC_W'(1) : clean_air;
  assign log_now = {norm_msb, LOG_ROM[norm_mant[NORM_W-2 -: LOG_IDX_W]]};
  assign d       = $signed({1'b0, log_a}) - $signed({1'b0, log_b});
  assign d_mag   = d[21] ? 22'(-d) : 22'(d);
  assign tb      = mul_p[37:16];
  assign y_next  = $signed(26'(COEF_C_MAG[curve_mode])) - $signed(26'(ta))
                 + (lg_neg ? $signed(26'(tb)) : -$signed(26'(tb)));
  assign y_mag   = y[25] ? 25'(-y) : 25'(y);
  assign t_mag   = mul_p[42:16];
  assign t       = y[25] ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
  assign f_bit   = f[4'(5'd16 - k)];
  assign out_free = !out_valid || !out_stall;
  assign shift_s = 12'sd30 - n;
  assign exp_val = {33'b0, man} >> shift_s[5:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_RS_GO;
      S_RS_GO:     state_next = (adc == '0) ? S_ACCUM : S_RS_WAIT;
      S_RS_WAIT:   if (div_done) state_next = S_ACCUM;
      S_ACCUM:     state_next = S_CHECK;
      S_CHECK:     state_next = win_end ? S_AVG_WAIT : S_IDLE;
      S_AVG_WAIT:  if (div_done) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (!cmd) state_next = S_REF_WAIT;
        else if (ref_res == '0 || avg == '0) state_next = S_OUT;
        else state_next = S_LOGA_WAIT;
      end
      S_REF_WAIT:  if (div_done) state_next = S_OUT;
      S_LOGA_WAIT: if (norm_done) state_next = S_LOGB_GO;
      S_LOGB_GO:   state_next = S_LOGB_WAIT;
      S_LOGB_WAIT: if (norm_done) state_next = S_LG_GO;
      S_LG_GO:     state_next = S_LG_WAIT;
      S_LG_WAIT:   if (mul_done) state_next = S_SQ_GO;
      S_SQ_GO:     state_next = S_SQ_WAIT;
      S_SQ_WAIT:   if (mul_done) state_next = S_A_GO;
      S_A_GO:      state_next = S_A_WAIT;
      S_A_WAIT:    if (mul_done) state_next = S_B_GO;
      S_B_GO:      state_next = S_B_WAIT;
      S_B_WAIT:    if (mul_done) state_next = S_T_GO;
      S_T_GO:      state_next = S_T_WAIT;
      S_T_WAIT:    if (mul_done) state_next = S_EXP_BIT;
      S_EXP_BIT: begin
        if (k > 5'd16) state_next = S_EXP_FIN;
        else if (f_bit) state_next = S_EXP_WAIT;
      end
      S_EXP_WAIT:  if (mul_done) state_next = S_EXP_BIT;
      S_EXP_FIN:   state_next = S_OUT;
      S_OUT:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // unit starts and operand selection
  always_comb begin
    in_stall     = (state != S_IDLE);
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    norm_start   = 1'b0;
    norm_x       = '0;
    case (state)
      S_RS_GO: begin
        div_start    = (adc != '0);
        div_dividend = DIV_DVD_W'({rs_num, {FRAC_BITS{1'b0}}});
        div_divisor  = DIV_DSR_W'(adc);
      end
      S_CHECK: begin
        div_start    = win_end;
        div_dividend = DIV_DVD_W'(sum);
        div_divisor  = DIV_DSR_W'(win_eff);
      end
      S_DISPATCH: begin
        div_start    = !cmd;
        div_dividend = {avg, 12'b0};
        div_divisor  = fac_eff;
        norm_start   = cmd && (ref_res != '0) && (avg != '0);
        norm_x       = avg;
      end
      S_LOGB_GO: begin
        norm_start = 1'b1;
        norm_x     = ref_res;
      end
      S_LG_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(d_mag);
        mul_b     = MUL_W'(LOG10_2_Q16);
      end
      S_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(lg_mag);
        mul_b     = MUL_W'(lg_mag);
      end
      S_A_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(sq);
        mul_b     = MUL_W'(COEF_A_MAG[curve_mode]);
      end
      S_B_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(lg_mag);
        mul_b     = MUL_W'(COEF_B_MAG[curve_mode]);
      end
      S_T_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(y_mag);
        mul_b     = MUL_W'(LOG2_10_Q16);
      end
      S_EXP_BIT: begin
        if (k <= 5'd16) begin
          mul_start = f_bit;
          mul_a     = MUL_W'(man);
          mul_b     = ROOT_ROM[k];
        end
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode  <= 1'b1;
      load_kohm   <= LOAD_W'(1);
      clean_air   <= FAC_W'(40137);
      cal_window  <= WIN_W'(20);
      meas_window <= WIN_W'(5);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CURVE_MODE:  curve_mode  <= cfg_data[0];
        REG_LOAD_KOHM:   load_kohm   <= cfg_data[LOAD_W-1:0];
        REG_CLEAN_AIR:   clean_air   <= cfg_data[FAC_W-1:0];
        REG_CAL_WINDOW:  cal_window  <= cfg_data[WIN_W-1:0];
        REG_MEAS_WINDOW: meas_window <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // window control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      count     <= '0;
      phase     <= 1'b0;
      ref_res   <= '0;
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result register: loaded at a window end, dropped once taken
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall)            out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            // a change of command drops the partial window
            if (count != '0 && in_data.command != phase) begin
              sum      <= '0;
              count    <= '0;
              sat_seen <= 1'b0;
            end
            phase <= in_data.command;
          end
        end
        S_RS_GO:   if (adc == '0) sat_seen <= 1'b1;
        S_RS_WAIT: if (div_done && div_quotient > DIV_DVD_W'(VAL_MAX)) sat_seen <= 1'b1;
        S_ACCUM: begin
          sum   <= sum + SUM_W'(rs_val);
          count <= count + 1'b1;
        end
        S_REF_WAIT: begin
          if (div_done) begin
            ref_res <= (div_quotient > DIV_DVD_W'(VAL_MAX)) ? VAL_MAX
                                                             : div_quotient[VAL_W-1:0];
          end
        end
        S_OUT: begin
          if (out_free) begin
            sum       <= '0;
            count     <= '0;
            sat_seen  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd <= in_data.command;
        adc <= in_data.adc_sample;
      end
      S_RS_GO: if (adc == '0) rs_val <= VAL_MAX;
      S_RS_WAIT: begin
        if (div_done) begin
          rs_val <= (div_quotient > DIV_DVD_W'(VAL_MAX)) ? VAL_MAX
                                                          : div_quotient[VAL_W-1:0];
        end
      end
      S_AVG_WAIT: if (div_done) avg <= div_quotient[VAL_W-1:0];
      S_DISPATCH: begin
        res_sat   <= sat_seen;
        res_uncal <= 1'b0;
        res_val   <= '0;
        if (cmd && ref_res == '0) begin
          res_uncal <= 1'b1;
        end else if (cmd && avg == '0 && !curve_mode) begin
          res_val <= VAL_MAX;
          res_sat <= 1'b1;
        end
      end
      S_REF_WAIT: begin
        if (div_done) begin
          if (div_quotient > DIV_DVD_W'(VAL_MAX)) begin
            res_val <= VAL_MAX;
            res_sat <= 1'b1;
          end else begin
            res_val <= div_quotient[VAL_W-1:0];
          end
        end
      end
      S_LOGA_WAIT: if (norm_done) log_a <= log_now;
      S_LOGB_WAIT: if (norm_done) log_b <= log_now;
      S_LG_WAIT: begin
        if (mul_done) begin
          lg_mag <= mul_p[35:16];
          lg_neg <= d[21];
        end
      end
      S_SQ_WAIT: if (mul_done) sq <= mul_p[39:16];
      S_A_WAIT:  if (mul_done) ta <= mul_p[39:16];
      S_B_WAIT:  if (mul_done) y <= y_next;
      S_T_WAIT: begin
        if (mul_done) begin
          n   <= t[27:16];
          f   <= t[15:0];
          man <= 31'd1 << 30;
          k   <= 5'd1;
        end
      end
      S_EXP_BIT: if (k <= 5'd16 && !f_bit) k <= k + 1'b1;
      S_EXP_WAIT: begin
        if (mul_done) begin
          man <= mul_p[60:30];
          k   <= k + 1'b1;
        end
      end
      S_EXP_FIN: begin
        // scale 2^f by 2^n and saturate
        if (n >= 12'sd20) begin
          res_val <= VAL_MAX;
          res_sat <= 1'b1;
        end else if (n <= -12'sd31) begin
          res_val <= '0;
        end else if (exp_val > 64'(VAL_MAX)) begin
          res_val <= VAL_MAX;
          res_sat <= 1'b1;
        end else begin
          res_val <= exp_val[VAL_W-1:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_data.result_kind  <= cmd;
          out_data.result_value <= res_val;
          out_data.saturated    <= res_sat;
          out_data.uncalibrated <= res_uncal;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sim/tb.sv]
// Self-checking testbench for the gas sensor ppm linearizer.
`timescale 1ns / 1ps

module tb;
  import gsl_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  gsl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gsl_out_t out_data;
  logic     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  gas_sensor_ppm_linearizer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Samples waiting to be sent, results predicted but not yet seen
  gsl_in_t  sample_q[$];
  gsl_out_t pending_results[$];
  int       errors = 0;

  // Predictor copy of configuration and window state
  logic        m_mode;
  logic [6:0]  m_load, m_calw, m_measw;
  logic [17:0] m_factor;
  longint      w_sum, w_count, ref_res;
  logic        w_phase, w_sat;

  // log2(1+i/256) in Q16 and 2^(2^-k) in Q30
  longint unsigned frac_log2 [256];
  longint unsigned pow2_root [17];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic build_tables();
    longint unsigned v;
    longint unsigned r;
    for (int i = 0; i < 256; i++) begin
      v = (longint'(256 + i) << 30) / 256;
      r = 0;
      for (int k = 0; k < 16; k++) begin
        v = (v * v) >> 30;
        r = r << 1;
        if (v >= (64'd2 << 30)) begin
          v = v >> 1;
          r = r | 1;
        end
      end
      frac_log2[i] = r;
    end
    pow2_root[0] = 64'd2 << 30;
    for (int k = 1; k <= 16; k++) pow2_root[k] = int_sqrt(pow2_root[k-1] << 30);
  endtask

  // Q16 product, truncated toward zero
  function automatic longint q16_mul(longint x, longint y);
    longint unsigned ax, ay, p;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    p = (ax * ay) >> 16;
    return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint log2_fx(longint unsigned x);
    longint unsigned e, f;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    if (e >= 16) f = (x >> (e - 16)) - 65536;
    else f = (x << (16 - e)) - 65536;
    return longint'(e) * 65536 + longint'(frac_log2[f >> 8]);
  endfunction

  // Methane ppm from average and reference resistance
  function automatic longint unsigned methane_ppm(longint unsigned avg, longint unsigned rref,
                                                  ref logic sat);
    longint ca, cb, cc, lg, y, t, n;
    longint unsigned fr, man, val;
    ca = m_mode ? -longint'(COEF_A_MAG[1]) : 0;
    cb = -longint'(COEF_B_MAG[m_mode]);
    cc = longint'(COEF_C_MAG[m_mode]);
    man = 64'd1 << 30;
    if (avg == 0) begin
      if (!m_mode) begin
        sat = 1'b1;
        return VAL_MAX;
      end
      return 0;
    end
    lg = q16_mul(log2_fx(avg) - log2_fx(rref), 19728);
    y = q16_mul(q16_mul(lg, lg), ca) + q16_mul(lg, cb) + cc;
    t = q16_mul(y, 217706);
    n = t >>> 16;
    fr = t & 64'hFFFF;
    for (int k = 1; k <= 16; k++)
      if ((fr >> (16 - k)) & 1) man = (man * pow2_root[k]) >> 30;
    if (n >= 20) begin
      sat = 1'b1;
      return VAL_MAX;
    end
    if (n <= -31) return 0;
    if (n >= 0) val = (man << n) >> 30;
    else val = man >> (30 - n);
    if (val > VAL_MAX) begin
      sat = 1'b1;
      return VAL_MAX;
    end
    return val;
  endfunction

  // Advance the window model by one accepted sample
  task automatic sensor_step(gsl_in_t s);
    longint unsigned rs, r, win, avg, fac;
    gsl_out_t res;
    logic sat;
    if (w_count != 0 && s.command != w_phase) begin
      w_sum = 0;
      w_count = 0;
      w_sat = 1'b0;
    end
    w_phase = s.command;
    if (s.adc_sample == 0) begin
      rs = VAL_MAX;
      w_sat = 1'b1;
    end else begin
      r = ((longint'(m_load) * (1023 - s.adc_sample)) << 10) / s.adc_sample;
      if (r > VAL_MAX) begin
        r = VAL_MAX;
        w_sat = 1'b1;
      end
      rs = r;
    end
    w_sum += rs;
    w_count++;
    win = s.command ? m_measw : m_calw;
    if (win == 0) win = 1;
    if (win > 64) win = 64;
    if (w_count < win) return;
    avg = w_sum / win;
    sat = w_sat;
    res = '0;
    res.result_kind = s.command;
    if (!s.command) begin
      fac = (m_factor != 0) ? m_factor : 1;
      r = (avg << 12) / fac;
      if (r > VAL_MAX) begin
        r = VAL_MAX;
        sat = 1'b1;
      end
      ref_res = r;
      res.result_value = VAL_W'(r);
    end else if (ref_res == 0) begin
      res.uncalibrated = 1'b1;
    end else begin
      res.result_value = VAL_W'(methane_ppm(avg, ref_res, sat));
    end
    res.saturated = sat;
    pending_results.push_back(res);
    w_sum = 0;
    w_count = 0;
    w_sat = 1'b0;
  endtask

  // Sender: bursts of beats with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sensor_step(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= sample_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a randomly redrawn stall density, plus one long hold-off
  logic hold_go = 1'b0, hold_done = 1'b0;
  int   hold_cnt = 0, stall_pct = 0, pct_age = 0;
  always @(posedge clk) begin
    pct_age <= (pct_age == 199) ? 0 : pct_age + 1;
    if (pct_age == 199) begin
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        default: stall_pct <= 75;
      endcase
    end
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        errors++;
      end else begin
        if (out_data !== pending_results[0]) begin
          $display("%0t: mismatch, expected %p, actual %p", $time,
                   pending_results[0], out_data);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  task automatic cfg_put(cfg_reg_t idx, int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    case (idx)
      REG_CURVE_MODE:  m_mode   = val[0];
      REG_LOAD_KOHM:   m_load   = val[6:0];
      REG_CLEAN_AIR:   m_factor = val[17:0];
      REG_CAL_WINDOW:  m_calw   = val[6:0];
      REG_MEAS_WINDOW: m_measw  = val[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Block idle: nothing queued or in flight, then let a sample finish
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (sample_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic int unsigned pick_window();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 64;
      2: return 127;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic random_config();
    cfg_put(REG_CURVE_MODE, $urandom_range(0, 1));
    cfg_put(REG_LOAD_KOHM, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(1, 100));
    case ($urandom_range(0, 5))
      0: cfg_put(REG_CLEAN_AIR, $urandom_range(0, 262143));
      1: cfg_put(REG_CLEAN_AIR, 4096);
      default: cfg_put(REG_CLEAN_AIR, $urandom_range(20000, 60000));
    endcase
    cfg_put(REG_CAL_WINDOW, pick_window());
    cfg_put(REG_MEAS_WINDOW, pick_window());
  endtask

  function automatic gsl_in_t mk(logic cmd, int unsigned adc);
    gsl_in_t s;
    s.command    = cmd;
    s.adc_sample = ADC_BITS'(adc);
    return s;
  endfunction

  // Mostly complete windows around a random level, some broken runs
  task automatic random_phase(int count);
    int unsigned base, len, win;
    logic cmd;
    while (count > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        cmd  = ($urandom_range(0, 3) != 0);
        win  = cmd ? m_measw : m_calw;
        len  = (win == 0) ? 1 : (win > 64) ? 64 : win;
        base = $urandom_range(0, 1023);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) == 0) sample_q.push_back(mk(cmd, $urandom_range(0, 1023)));
          else sample_q.push_back(mk(cmd, (base + $urandom_range(0, 8)) % 1024));
        end
        count -= len;
      end else begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          sample_q.push_back(mk($urandom_range(0, 1), $urandom_range(0, 1023)));
        count -= len;
      end
    end
  endtask

  initial begin
    build_tables();
    m_mode = 1'b1; m_load = 7'd1; m_factor = 18'd40137; m_calw = 7'd20; m_measw = 7'd5;
    w_sum = 0; w_count = 0; w_phase = 1'b0; ref_res = 0; w_sat = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Measurement before any calibration, default settings
    for (int i = 0; i < 5; i++) sample_q.push_back(mk(1'b1, 200 + i));
    drain();

    // Directed: small windows, extreme samples, command switch mid-window
    cfg_put(REG_CAL_WINDOW, 2);
    cfg_put(REG_MEAS_WINDOW, 1);
    cfg_put(REG_LOAD_KOHM, 10);
    sample_q.push_back(mk(1'b0, 512));
    sample_q.push_back(mk(1'b0, 500));
    sample_q.push_back(mk(1'b1, 0));
    sample_q.push_back(mk(1'b1, 1023));
    sample_q.push_back(mk(1'b1, 1));
    sample_q.push_back(mk(1'b1, 100));
    sample_q.push_back(mk(1'b1, 900));
    sample_q.push_back(mk(1'b0, 0));
    sample_q.push_back(mk(1'b1, 300));
    sample_q.push_back(mk(1'b0, 1023));
    sample_q.push_back(mk(1'b0, 1023));
    drain();
    cfg_put(REG_CURVE_MODE, 0);
    sample_q.push_back(mk(1'b1, 1023));
    sample_q.push_back(mk(1'b0, 1));
    sample_q.push_back(mk(1'b0, 2));
    sample_q.push_back(mk(1'b1, 1));
    sample_q.push_back(mk(1'b1, 600));
    drain();

    // Extremes of every register
    cfg_put(REG_LOAD_KOHM, 127);
    cfg_put(REG_CLEAN_AIR, 0);
    cfg_put(REG_CAL_WINDOW, 0);
    cfg_put(REG_MEAS_WINDOW, 0);
    sample_q.push_back(mk(1'b0, 3));
    sample_q.push_back(mk(1'b1, 1000));
    drain();
    cfg_put(REG_CLEAN_AIR, 262143);
    cfg_put(REG_CURVE_MODE, 1);
    sample_q.push_back(mk(1'b0, 3));
    sample_q.push_back(mk(1'b1, 1022));
    drain();

    // Long receiver hold-off with the sender still offering samples
    cfg_put(REG_LOAD_KOHM, 20);
    cfg_put(REG_CLEAN_AIR, 40137);
    cfg_put(REG_CAL_WINDOW, 1);
    cfg_put(REG_MEAS_WINDOW, 1);
    hold_go = 1'b1;
    random_phase(100);
    drain();

    // Random phases over a range of settings
    for (int p = 0; p < 13; p++) begin
      random_config();
      random_phase(100);
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #(200_000_000);
    $display("tb: FAIL");
    $finish;
  end

endmodule
